// ===== hw/rtl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque package
// Shared widths, operation codes, status codes, cell commands and the
// sequencer state type of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int OCC_W         = 7;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_WALK_FRONT = 3'd4,
        OP_WALK_BACK  = 3'd5,
        OP_LENGTH     = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain in the same cycle.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_ROT_LEFT,
        CMD_ROT_RIGHT
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK_FRONT,
        ST_WALK_BACK
    } state_t;

endpackage : deq_pkg
`default_nettype wire

// ===== hw/rtl/deq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque cell
// One storage slot of the chain. It holds a value and a valid flag and moves
// its value to or from its neighbors as the broadcast command says.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_cmd_t                cmd,
    input  wire logic signed [DATA_W-1:0] push_data,
    input  wire logic signed [DATA_W-1:0] head_data,
    input  wire logic signed [DATA_W-1:0] prev_data,
    input  wire logic                     prev_valid,
    input  wire logic signed [DATA_W-1:0] next_data,
    input  wire logic                     next_valid,
    output logic signed [DATA_W-1:0]      data,
    output logic                          valid,
    output logic                          tail
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     is_tail;

    // The tail is the last occupied cell of the chain.
    assign is_tail = valid_reg && !next_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                data_next  = prev_data;
                valid_next = prev_valid;
            end
            CMD_PUSH_BACK:
            begin
                if (!valid_reg && prev_valid)
                begin
                    data_next  = push_data;
                    valid_next = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                data_next  = next_data;
                valid_next = next_valid;
            end
            CMD_POP_BACK:
            begin
                if (is_tail)
                begin
                    valid_next = 1'b0;
                end
            end
            CMD_ROT_LEFT:
            begin
                if (valid_reg)
                begin
                    data_next = is_tail ? head_data : next_data;
                end
            end
            CMD_ROT_RIGHT:
            begin
                if (valid_reg)
                begin
                    data_next = prev_data;
                end
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign tail  = is_tail;

endmodule : deq_cell
`default_nettype wire

// ===== hw/rtl/deq_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque cell chain
// A row of DEPTH cells; cell 0 holds the front value. Also presents the front
// value and the value of the tail cell.
// ----------------------------------------------------------------------------
module deq_chain
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_cmd_t                cmd,
    input  wire logic signed [DATA_W-1:0] push_data,
    output logic signed [DATA_W-1:0]      head_data,
    output logic signed [DATA_W-1:0]      tail_data
);

    logic signed [DATA_W-1:0] cell_data  [DEPTH];
    logic                     cell_valid [DEPTH];
    logic                     cell_tail  [DEPTH];
    logic signed [DATA_W-1:0] first_prev_data;

    // On a right rotation the tail value wraps into the front cell; otherwise
    // the front cell takes the pushed value.
    assign first_prev_data = (cmd == CMD_ROT_RIGHT) ? tail_data : push_data;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_d;
        logic                     prev_v;
        logic signed [DATA_W-1:0] next_d;
        logic                     next_v;

        if (i == 0)
        begin : g_first
            assign prev_d = first_prev_data;
            assign prev_v = 1'b1;
        end
        else
        begin : g_inner_prev
            assign prev_d = cell_data[i-1];
            assign prev_v = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = '0;
            assign next_v = 1'b0;
        end
        else
        begin : g_inner_next
            assign next_d = cell_data[i+1];
            assign next_v = cell_valid[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .push_data  (push_data),
            .head_data  (cell_data[0]),
            .prev_data  (prev_d),
            .prev_valid (prev_v),
            .next_data  (next_d),
            .next_valid (next_v),
            .data       (cell_data[i]),
            .valid      (cell_valid[i]),
            .tail       (cell_tail[i])
        );
    end

    assign head_data = cell_data[0];

    // At most one cell is the tail, so an AND-OR select picks its value.
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_data = tail_data | (cell_data[i] & {DATA_W{cell_tail[i]}});
        end
    end

endmodule : deq_chain
`default_nettype wire

// ===== hw/rtl/double_ended_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue
// A bounded deque of signed 32-bit values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (operation, data_in) is taken at a rising edge where start is
//   high and busy is low. Every result appears on data_out, occupancy,
//   status and last for exactly one cycle, marked by done; the receiver must
//   take it then, since it cannot hold results off.
//   Push, pop and length requests leave busy low: a new request may be
//   given every cycle, and the single result (last set) shows in the cycle
//   after the request is taken.
//   A walk of n stored values keeps busy high while it runs and gives one
//   result per cycle, front or back value first, with last on the final
//   one; the block is free again once the walk has given its last value.
//   The walk rotates the cell chain once per value.
//   An empty walk or pop gives one result with the empty status, and a push
//   into a full deque gives the full status and leaves the contents as they
//   were. Reset clears every cell's valid flag and the count, so the deque
//   comes out of reset empty and ready.
// ----------------------------------------------------------------------------
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [DATA_W-1:0] data_in,
    output logic                          done,
    output logic signed [DATA_W-1:0]      data_out,
    output logic [OCC_W-1:0]              occupancy,
    output logic [STATUS_W-1:0]           status,
    output logic                          last
);

    localparam logic [OCC_W-1:0] FULL_COUNT = OCC_W'(DEPTH);

    state_t                   state_reg;
    state_t                   state_next;
    logic [OCC_W-1:0]         count_reg;
    logic [OCC_W-1:0]         count_next;
    logic [OCC_W-1:0]         remain_reg;
    logic [OCC_W-1:0]         remain_next;

    logic                     done_reg;
    logic                     done_next;
    logic signed [DATA_W-1:0] data_out_reg;
    logic signed [DATA_W-1:0] data_out_next;
    logic [OCC_W-1:0]         occupancy_reg;
    logic [OCC_W-1:0]         occupancy_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic                     last_reg;
    logic                     last_next;

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] head_data;
    logic signed [DATA_W-1:0] tail_data;
    logic                     accept;
    logic                     is_empty;
    logic                     is_full;

    deq_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .push_data (data_in),
        .head_data (head_data),
        .tail_data (tail_data)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg >= FULL_COUNT);

    // Sequencer: push, pop and length requests are decoded in idle; walks step the
    // chain by one rotation per cycle and emit one value each time.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        cmd            = CMD_HOLD;
        done_next      = 1'b0;
        data_out_next  = '0;
        occupancy_next = count_reg;
        status_next    = STATUS_OK;
        last_next      = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (op_t'(operation))
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                cmd = (op_t'(operation) == OP_PUSH_FRONT) ?
                                      CMD_PUSH_FRONT : CMD_PUSH_BACK;
                                count_next     = count_reg + 1'b1;
                                occupancy_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else if (op_t'(operation) == OP_POP_FRONT)
                            begin
                                cmd            = CMD_POP_FRONT;
                                data_out_next  = head_data;
                                count_next     = count_reg - 1'b1;
                                occupancy_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                cmd            = CMD_POP_BACK;
                                data_out_next  = tail_data;
                                count_next     = count_reg - 1'b1;
                                occupancy_next = count_reg - 1'b1;
                            end
                        end
                        OP_WALK_FRONT, OP_WALK_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // No result yet; the walk state gives the first value.
                                done_next   = 1'b0;
                                remain_next = count_reg;
                                state_next  = (op_t'(operation) == OP_WALK_FRONT) ?
                                              ST_WALK_FRONT : ST_WALK_BACK;
                            end
                        end
                        default:
                        begin
                            // Length request; the unused code answers the same.
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_WALK_FRONT, ST_WALK_BACK:
            begin
                done_next = 1'b1;
                if (state_reg == ST_WALK_FRONT)
                begin
                    cmd           = CMD_ROT_LEFT;
                    data_out_next = head_data;
                end
                else
                begin
                    cmd           = CMD_ROT_RIGHT;
                    data_out_next = tail_data;
                end
                last_next   = (remain_reg == OCC_W'(1));
                remain_next = remain_reg - 1'b1;
                if (remain_reg == OCC_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg  <= data_out_next;
        occupancy_reg <= occupancy_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign done      = done_reg;
    assign data_out  = data_out_reg;
    assign occupancy = occupancy_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule : double_ended_queue_top
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, walk and length requests into the deque and checks
// every result against a predictor that keeps its own copy of the ring
// contents, or against the result written in a directed row. A short table
// of directed requests comes first. A fill-to-capacity pass and a run of
// random requests with random gaps follow.
module tb_top;
    import deq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    // The selector left over in the operation field; it must act like a length request.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    // Cycles without any accepted item or result before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    localparam int NUM_ROWS = 25;
    localparam int RANDOM_ITEMS = 60;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [OCC_W-1:0]         occ;
        status_t                  status;
        logic                     last;
    } deq_result_t;

    // One row of the directed table. Where typed is set, the expected result is
    // written in the row itself instead of coming from the predictor.
    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        deq_result_t              res;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [OP_W-1:0]          operation = '0;
    logic signed [DATA_W-1:0] data_in = '0;
    wire logic                busy;
    wire logic                done;
    wire logic signed [DATA_W-1:0] data_out;
    wire logic [OCC_W-1:0]    occupancy;
    wire logic [STATUS_W-1:0] status;
    wire logic                last;

    // Typed expectation that travels with the item on the request ports.
    bit          typed_item = 1'b0;
    deq_result_t typed_result = '{32'sd0, 7'd0, STATUS_OK, 1'b0};
    deq_result_t no_typed = '{32'sd0, 7'd0, STATUS_OK, 1'b0};

    // Predictor state: ring contents, front slot and number of held values.
    logic signed [DATA_W-1:0] model_ring [DEPTH];
    int unsigned              model_front = 0;
    int unsigned              model_count = 0;

    // Results still owed by the block, oldest first.
    deq_result_t pending_results [$];

    stim_row_t directed_rows [NUM_ROWS];

    int  error_count = 0;
    int  items_accepted = 0;
    int  results_checked = 0;
    int  full_seen = 0;
    int  empty_seen = 0;
    int  idle_cycles = 0;
    bit  idle_on = 1'b1;

    double_ended_queue_top #(
        .DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .data_in   (data_in),
        .done      (done),
        .data_out  (data_out),
        .occupancy (occupancy),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The occupancy field always reports the count after the step, so it is
    // taken from the predictor state at the moment the result is queued.
    function automatic void owe_result(input logic signed [DATA_W-1:0] data,
                                       input status_t st, input logic fin);
        deq_result_t r;
        r.data   = data;
        r.occ    = OCC_W'(model_count);
        r.status = st;
        r.last   = fin;
        pending_results.push_back(r);
    endfunction

    // Applies one request to the predictor state and queues what it must produce.
    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic signed [DATA_W-1:0] value);
        int unsigned n;
        int unsigned slot;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (model_count >= DEPTH) begin
                    owe_result(32'sd0, STATUS_FULL, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        model_front = (model_front + DEPTH - 1) % DEPTH;
                        model_ring[model_front] = value;
                    end else begin
                        model_ring[(model_front + model_count) % DEPTH] = value;
                    end
                    model_count++;
                    owe_result(32'sd0, STATUS_OK, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (model_count == 0) begin
                    owe_result(32'sd0, STATUS_EMPTY, 1'b1);
                end else if (op == OP_POP_FRONT) begin
                    slot = model_front;
                    model_front = (model_front + 1) % DEPTH;
                    model_count--;
                    owe_result(model_ring[slot], STATUS_OK, 1'b1);
                end else begin
                    slot = (model_front + model_count - 1) % DEPTH;
                    model_count--;
                    owe_result(model_ring[slot], STATUS_OK, 1'b1);
                end
            end
            OP_WALK_FRONT, OP_WALK_BACK:
            begin
                if (model_count == 0) begin
                    owe_result(32'sd0, STATUS_EMPTY, 1'b1);
                end else begin
                    for (n = 0; n < model_count; n++) begin
                        if (op == OP_WALK_FRONT)
                            slot = (model_front + n) % DEPTH;
                        else
                            slot = (model_front + model_count - 1 - n) % DEPTH;
                        owe_result(model_ring[slot], STATUS_OK, n + 1 == model_count);
                    end
                end
            end
            // Length requests and the unused selector report the count only.
            default: owe_result(32'sd0, STATUS_OK, 1'b1);
        endcase
    endfunction

    // Mostly back-to-back items, some short gaps and a rare long one. Inside a
    // stretch with idling switched off, every item follows the last at once.
    function automatic int pick_gap();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Extremes and sign boundaries now and then, otherwise a full random word.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Pushes dominate while filling and pops while draining, so the deque
    // swings up and down over the random run.
    function automatic logic [OP_W-1:0] pick_operation(input bit filling);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return OP_LENGTH;
        if (r < 6)
            return OP_UNUSED;
        if (r < 11)
            return OP_WALK_FRONT;
        if (r < 16)
            return OP_WALK_BACK;
        if (r < (filling ? 80 : 36))
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // Presents one item and holds it until the block takes it. The busy value
    // seen right after an edge is the one the block saw at that edge.
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                             input bit typed, input deq_result_t res);
        int gap;
        start        <= 1'b1;
        operation    <= op;
        data_in      <= value;
        typed_item   <= typed;
        typed_result <= res;
        do
            @(posedge clk);
        while (busy);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Checks results first and takes new items second, so a result that shows
    // at the same edge as an acceptance is matched against older expectations.
    always @(posedge clk)
    begin
        deq_result_t want;
        idle_cycles++;
        if (rst_n && done) begin
            idle_cycles = 0;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: data_out %0d occupancy %0d status %0d",
                       data_out, occupancy, status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.status == STATUS_FULL)
                    full_seen++;
                if (want.status == STATUS_EMPTY)
                    empty_seen++;
                if (data_out !== want.data) begin
                    $error("data_out: expected %0d, actual %0d", want.data, data_out);
                    error_count++;
                end
                if (occupancy !== want.occ) begin
                    $error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
                    error_count++;
                end
                if (status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    error_count++;
                end
            end
        end
        if (rst_n && start && !busy) begin
            idle_cycles = 0;
            items_accepted++;
            predict_request(operation, data_in);
            if (typed_item)
                pending_results[pending_results.size() - 1] = typed_result;
        end
    end

    // Ends a hung run: nothing taken in or given out for too long.
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("double_ended_queue_top: mismatch");
        $finish;
    end

    initial
    begin
        int n;
        // Directed requests. The rows with written-in results cover reset,
        // empty errors, the unused selector and values at the 32-bit extremes;
        // the first push to the front wraps the front slot below zero.
        directed_rows = '{
            '{OP_LENGTH,     32'sd0,          1'b1, '{32'sd0, 7'd0, STATUS_OK,    1'b1}},
            '{OP_POP_FRONT,  32'sh12345678,   1'b1, '{32'sd0, 7'd0, STATUS_EMPTY, 1'b1}},
            '{OP_POP_BACK,   -32'sd1,         1'b1, '{32'sd0, 7'd0, STATUS_EMPTY, 1'b1}},
            '{OP_WALK_FRONT, 32'sd0,          1'b1, '{32'sd0, 7'd0, STATUS_EMPTY, 1'b1}},
            '{OP_WALK_BACK,  32'sh7FFFFFFF,   1'b1, '{32'sd0, 7'd0, STATUS_EMPTY, 1'b1}},
            '{OP_UNUSED,     32'sh80000000,   1'b1, '{32'sd0, 7'd0, STATUS_OK,    1'b1}},
            '{OP_PUSH_FRONT, 32'sh7FFFFFFF,   1'b1, '{32'sd0, 7'd1, STATUS_OK,    1'b1}},
            '{OP_PUSH_BACK,  32'sh80000000,   1'b1, '{32'sd0, 7'd2, STATUS_OK,    1'b1}},
            '{OP_PUSH_FRONT, -32'sd1,         1'b0, no_typed},
            '{OP_PUSH_BACK,  32'sd0,          1'b0, no_typed},
            '{OP_PUSH_FRONT, 32'sd1,          1'b0, no_typed},
            '{OP_WALK_FRONT, 32'sh12345678,   1'b0, no_typed},
            '{OP_WALK_BACK,  -32'sd1,         1'b0, no_typed},
            '{OP_LENGTH,     32'sh55555555,   1'b0, no_typed},
            '{OP_POP_FRONT,  32'sd0,          1'b0, no_typed},
            '{OP_POP_BACK,   32'sd0,          1'b0, no_typed},
            '{OP_POP_FRONT,  32'sd0,          1'b0, no_typed},
            '{OP_POP_BACK,   32'sd0,          1'b0, no_typed},
            '{OP_POP_FRONT,  32'sd0,          1'b1, '{32'sh7FFFFFFF, 7'd0, STATUS_OK, 1'b1}},
            '{OP_POP_BACK,   32'sd0,          1'b1, '{32'sd0, 7'd0, STATUS_EMPTY, 1'b1}},
            '{OP_PUSH_BACK,  32'sh55555555,   1'b0, no_typed},
            '{OP_PUSH_BACK,  32'shAAAAAAAA,   1'b0, no_typed},
            '{OP_WALK_BACK,  32'sd0,          1'b0, no_typed},
            '{OP_POP_FRONT,  32'sd0,          1'b0, no_typed},
            '{OP_POP_FRONT,  32'sd0,          1'b0, no_typed}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].res);

        // The table leaves the deque empty. Fill it from both ends to capacity,
        // push into it once while full, then walk all of it both ways.
        for (n = 0; n < DEPTH + 1; n++)
            send_item($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                      pick_value(), 1'b0, no_typed);
        send_item(OP_WALK_FRONT, pick_value(), 1'b0, no_typed);
        send_item(OP_WALK_BACK, pick_value(), 1'b0, no_typed);

        // Random requests. The deque starts full, so the first block of 25
        // items leans to pops and the balance flips after each such block.
        // Every third block of 20 items runs with no idling at all.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = ((n / 20) % 3) != 2;
            send_item(pick_operation(((n / 25) % 2) == 1), pick_value(), 1'b0, no_typed);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // A full walk is the longest the block can still be at work.
        repeat (DEPTH + 4) @(posedge clk);

        $display("Covered %0d requests and checked %0d results,", items_accepted,
                 results_checked);
        $display("among them %0d full and %0d empty responses.", full_seen, empty_seen);
        if (error_count == 0)
            $display("double_ended_queue_top: match");
        else
            $display("double_ended_queue_top: mismatch");
        $finish;
    end

endmodule
